// ----- design/vn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// vn2d_pkg: shared types and constants for the 2D value noise block
// Field widths, fixed-point constants, queue depths and the request record
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package vn2d_pkg;

  // Port field widths
  localparam int AXIS_W  = 8;   // lattice row / column index
  localparam int VAL_W   = 16;  // Q0.16 lattice and noise values
  localparam int COORD_W = 32;  // query coordinates

  // Smoothstep arithmetic: s = (t*t*(3*2^16 - 2t) + 2^31) >> 32
  localparam int WT_W  = 17;  // Q1.16 weight, 0..65536
  localparam int TSQ_W = 32;  // t*t
  localparam int U_W   = 18;  // 3*2^16 - 2t
  localparam int P_W   = TSQ_W + U_W;
  localparam logic [U_W-1:0] SS_THREE = U_W'(3 * 65536);
  localparam logic [P_W-1:0] SS_ROUND = P_W'(64'd1 << 31);

  // Request codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Queue depths
  localparam int MID_DEPTH  = 8;
  localparam int OUT_DEPTH  = 4;
  localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Classified request, front end to back end
  typedef struct packed {
    logic              query;
    logic [AXIS_W-1:0] row;
    logic [AXIS_W-1:0] col;
    logic [VAL_W-1:0]  value;
    logic [AXIS_W-1:0] x0;
    logic [AXIS_W-1:0] x1;
    logic [AXIS_W-1:0] y0;
    logic [AXIS_W-1:0] y1;
    logic [WT_W-1:0]   wx;
    logic [WT_W-1:0]   wy;
  } vn2d_item_t;

  localparam int ITEM_W = $bits(vn2d_item_t);

endpackage

// ----- design/vn2d_fifo.sv -----
// ----------------------------------------------------------------------------
// vn2d_fifo: small register FIFO
// Holds requests or results between pipeline parts. Writers keep their own credit
// count, so no overflow check is done here.
// ----------------------------------------------------------------------------
module vn2d_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/vn2d_front.sv -----
// ----------------------------------------------------------------------------
// vn2d_front: request intake and classification
// Splits coordinates, wraps the cell index modulo GRID_SIZE-1 by reciprocal
// multiply and one correction, computes smoothstep weights. Three stages,
// never stalls; intake is throttled by a credit count on the request queue.
// ----------------------------------------------------------------------------
module vn2d_front
  import vn2d_pkg::*;
#(
  parameter int GRID_SIZE = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic [AXIS_W-1:0]  load_row,
  input  logic [AXIS_W-1:0]  load_col,
  input  logic [VAL_W-1:0]   load_value,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  output logic               item_valid,
  output vn2d_item_t         item,
  input  logic               item_taken
);

  localparam int INT_W       = COORD_W - FRAC_BITS;
  localparam int MOD         = GRID_SIZE - 1;
  localparam int IDX_W       = $clog2(GRID_SIZE);
  localparam int REM_W       = IDX_W + 1;
  localparam int RECIP_SHIFT = INT_W + 8;
  localparam int RECIP_W     = RECIP_SHIFT - 1;
  localparam int PROD_W      = INT_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int T_SHIFT     = VAL_W - FRAC_BITS;
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << RECIP_SHIFT) / MOD);
  localparam logic [IDX_W-1:0]   IDX_MASK = IDX_W'(GRID_SIZE - 1);

  logic               accept;
  logic [MID_CNT_W-1:0] used;
  logic [INT_W-1:0]   n_x, n_y;
  logic [VAL_W-1:0]   t_x, t_y;

  // stage 1
  logic               s1_valid, s1_query;
  logic [AXIS_W-1:0]  s1_row, s1_col;
  logic [VAL_W-1:0]   s1_value;
  logic [INT_W-1:0]   s1_n_x, s1_n_y;
  logic [PROD_W-1:0]  s1_prod_x, s1_prod_y;
  logic [TSQ_W-1:0]   s1_tsq_x, s1_tsq_y;
  logic [U_W-1:0]     s1_u_x, s1_u_y;
  logic [Q_W-1:0]     q_x, q_y;
  logic [P_W-1:0]     p_x, p_y;

  // stage 2
  logic               s2_valid, s2_query;
  logic [AXIS_W-1:0]  s2_row, s2_col;
  logic [VAL_W-1:0]   s2_value;
  logic [REM_W-1:0]   s2_n_x, s2_n_y, s2_qd_x, s2_qd_y;
  logic [WT_W-1:0]    s2_wx, s2_wy;

  // stage 3
  logic               s3_valid, s3_query;
  logic [AXIS_W-1:0]  s3_row, s3_col;
  logic [VAL_W-1:0]   s3_value;
  logic [REM_W-1:0]   s3_r_x, s3_r_y;
  logic [WT_W-1:0]    s3_wx, s3_wy;
  logic [REM_W-1:0]   fix_x, fix_y;
  logic [IDX_W-1:0]   ix, iy;

  assign accept = push && !full;
  assign full   = (used == MID_CNT_W'(MID_DEPTH));

  assign n_x = coord_x[COORD_W-1:FRAC_BITS];
  assign n_y = coord_y[COORD_W-1:FRAC_BITS];
  assign t_x = VAL_W'(coord_x[FRAC_BITS-1:0]) << T_SHIFT;
  assign t_y = VAL_W'(coord_y[FRAC_BITS-1:0]) << T_SHIFT;

  // queue credit: requests in flight here plus those waiting in the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (accept && !item_taken) begin
      used <= used + MID_CNT_W'(1);
    end else if (!accept && item_taken) begin
      used <= used - MID_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 1: reciprocal product, t*t and 3-2t
  always_ff @(posedge clk) begin
    s1_query  <= (action == ACT_QUERY);
    s1_row    <= load_row;
    s1_col    <= load_col;
    s1_value  <= load_value;
    s1_n_x    <= n_x;
    s1_n_y    <= n_y;
    s1_prod_x <= PROD_W'(n_x) * PROD_W'(RECIP);
    s1_prod_y <= PROD_W'(n_y) * PROD_W'(RECIP);
    s1_tsq_x  <= TSQ_W'(t_x) * TSQ_W'(t_x);
    s1_tsq_y  <= TSQ_W'(t_y) * TSQ_W'(t_y);
    s1_u_x    <= SS_THREE - U_W'({t_x, 1'b0});
    s1_u_y    <= SS_THREE - U_W'({t_y, 1'b0});
  end

  // quotient estimate is low by at most one
  assign q_x = s1_prod_x[PROD_W-1:RECIP_SHIFT];
  assign q_y = s1_prod_y[PROD_W-1:RECIP_SHIFT];
  assign p_x = P_W'(s1_tsq_x) * P_W'(s1_u_x) + SS_ROUND;
  assign p_y = P_W'(s1_tsq_y) * P_W'(s1_u_y) + SS_ROUND;

  // stage 2: q*MOD (low bits only), rounded weights
  always_ff @(posedge clk) begin
    s2_query <= s1_query;
    s2_row   <= s1_row;
    s2_col   <= s1_col;
    s2_value <= s1_value;
    s2_n_x   <= REM_W'(s1_n_x);
    s2_n_y   <= REM_W'(s1_n_y);
    s2_qd_x  <= REM_W'(q_x) * REM_W'(MOD);
    s2_qd_y  <= REM_W'(q_y) * REM_W'(MOD);
    s2_wx    <= p_x[P_W-2:32];
    s2_wy    <= p_y[P_W-2:32];
  end

  // stage 3: remainder, below 2*MOD
  always_ff @(posedge clk) begin
    s3_query <= s2_query;
    s3_row   <= s2_row;
    s3_col   <= s2_col;
    s3_value <= s2_value;
    s3_r_x   <= s2_n_x - s2_qd_x;
    s3_r_y   <= s2_n_y - s2_qd_y;
    s3_wx    <= s2_wx;
    s3_wy    <= s2_wy;
  end

  assign fix_x = (s3_r_x >= REM_W'(MOD)) ? s3_r_x - REM_W'(MOD) : s3_r_x;
  assign fix_y = (s3_r_y >= REM_W'(MOD)) ? s3_r_y - REM_W'(MOD) : s3_r_y;
  assign ix    = IDX_W'(fix_x);
  assign iy    = IDX_W'(fix_y);

  assign item_valid  = s3_valid;
  assign item.query  = s3_query;
  assign item.row    = s3_row;
  assign item.col    = s3_col;
  assign item.value  = s3_value;
  assign item.x0     = AXIS_W'(ix & IDX_MASK);
  assign item.x1     = AXIS_W'((ix + IDX_W'(1)) & IDX_MASK);
  assign item.y0     = AXIS_W'(iy & IDX_MASK);
  assign item.y1     = AXIS_W'((iy + IDX_W'(1)) & IDX_MASK);
  assign item.wx     = s3_wx;
  assign item.wy     = s3_wy;

endmodule

// ----- design/vn2d_back.sv -----
// ----------------------------------------------------------------------------
// vn2d_back: lattice storage and interpolation
// Two copies of the lattice, each with two read ports, give all four corners
// in the same cycle. Loads write both copies. Queries blend along x, then y.
// ----------------------------------------------------------------------------
module vn2d_back
  import vn2d_pkg::*;
#(
  parameter int GRID_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  vn2d_item_t       item,
  output logic             item_pop,
  output logic             res_valid,
  output logic [VAL_W-1:0] res_value,
  input  logic             res_taken
);

  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int LAT_AW    = 2 * IDX_W;
  localparam int LAT_DEPTH = 1 << LAT_AW;
  localparam logic [AXIS_W:0] GRID_LIM = (AXIS_W + 1)'(GRID_SIZE);

  // a + (b-a)*s, rounded half up; never leaves 0..65535
  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [WT_W-1:0]  s);
    logic signed [VAL_W:0]  d;
    logic signed [34:0]     acc;
    d   = signed'({1'b0, b}) - signed'({1'b0, a});
    acc = signed'(35'({a, 16'h8000})) + d * signed'({1'b0, s});
    return acc[31:16];
  endfunction

  logic [VAL_W-1:0] lat_y0 [LAT_DEPTH];
  logic [VAL_W-1:0] lat_y1 [LAT_DEPTH];

  logic [OUT_CNT_W-1:0] out_used;
  logic                 q_pop, ld_pop, ld_in_grid;
  logic [LAT_AW-1:0]    wr_addr, a00, a10, a01, a11;

  logic             b1_valid;
  logic [WT_W-1:0]  b1_wx, b1_wy;
  logic [VAL_W-1:0] c00, c10, c01, c11;

  logic             b2_valid;
  logic [WT_W-1:0]  b2_wy;
  logic [VAL_W-1:0] b2_p0, b2_p1;

  // queries need a slot in the result queue; loads go straight through
  assign item_pop = item_valid &&
                    (!item.query || out_used != OUT_CNT_W'(OUT_DEPTH));
  assign q_pop    = item_pop && item.query;
  assign ld_pop   = item_pop && !item.query;

  // entries outside the grid are never read
  assign ld_in_grid = ({1'b0, item.row} < GRID_LIM) && ({1'b0, item.col} < GRID_LIM);

  assign wr_addr = {item.row[IDX_W-1:0], item.col[IDX_W-1:0]};
  assign a00     = {item.x0[IDX_W-1:0], item.y0[IDX_W-1:0]};
  assign a10     = {item.x1[IDX_W-1:0], item.y0[IDX_W-1:0]};
  assign a01     = {item.x0[IDX_W-1:0], item.y1[IDX_W-1:0]};
  assign a11     = {item.x1[IDX_W-1:0], item.y1[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_used <= '0;
    end else if (q_pop && !res_taken) begin
      out_used <= out_used + OUT_CNT_W'(1);
    end else if (!q_pop && res_taken) begin
      out_used <= out_used - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_pop && ld_in_grid) begin
      lat_y0[wr_addr] <= item.value;
    end
    c00 <= lat_y0[a00];
    c10 <= lat_y0[a10];
  end

  always_ff @(posedge clk) begin
    if (ld_pop && ld_in_grid) begin
      lat_y1[wr_addr] <= item.value;
    end
    c01 <= lat_y1[a01];
    c11 <= lat_y1[a11];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop;
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_wx <= item.wx;
    b1_wy <= item.wy;
    b2_p0 <= blend(c00, c10, b1_wx);
    b2_p1 <= blend(c01, c11, b1_wx);
    b2_wy <= b1_wy;
  end

  assign res_valid = b2_valid;
  assign res_value = blend(b2_p0, b2_p1, b2_wy);

endmodule

// ----- design/value_noise_2d_lattice_top.sv -----
// ----------------------------------------------------------------------------
// value_noise_2d_lattice_top: 2D value noise over a loadable lattice
// Smoothstep-weighted bilinear interpolation of a GRID_SIZE x GRID_SIZE
// lattice of Q0.16 values, returning Q0.16 noise.
// ----------------------------------------------------------------------------
// Takes one request per clock while full is low, loads and queries mixed
// freely, and returns one noise result per clock while pop is held. A load
// (action 0) writes one lattice entry and gives no result; a query (action 1)
// gives exactly one result, in request order. A query passes through three
// front-end stages (cell wrap and smoothstep), the request queue, the
// registered lattice read, one x-blend stage, then the result queue. The
// lattice is held twice, each copy with two read ports, so all four corners
// are read in the same cycle; a load written in one cycle is seen by a query
// the next. Entries are undefined after reset and must be loaded before a
// query touches them; there is no clearing pass. Loads to rows or columns at
// or beyond GRID_SIZE are dropped, as nothing ever reads them.
// ----------------------------------------------------------------------------
module value_noise_2d_lattice_top
  import vn2d_pkg::*;
#(
  parameter int GRID_SIZE = 256,  // 4..256
  parameter int FRAC_BITS = 16    // 8..16
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic [AXIS_W-1:0]  load_row,
  input  logic [AXIS_W-1:0]  load_col,
  input  logic [VAL_W-1:0]   load_value,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [VAL_W-1:0]   noise_value
);

  logic             fr_valid;
  vn2d_item_t       fr_item;
  logic             mid_empty;
  logic [ITEM_W-1:0] mid_head;
  logic             mid_pop;
  logic             res_valid;
  logic [VAL_W-1:0] res_value;
  logic             res_taken;

  assign res_taken = pop && !empty;

  // front end: intake, cell wrap, smoothstep weights
  vn2d_front #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .load_row   (load_row),
    .load_col   (load_col),
    .load_value (load_value),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .item_valid (fr_valid),
    .item       (fr_item),
    .item_taken (mid_pop)
  );

  // request queue: lets the front run while the back waits on results
  vn2d_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_valid),
    .din   (fr_item),
    .pop   (mid_pop),
    .dout  (mid_head),
    .empty (mid_empty)
  );

  // back end: lattice storage and blending
  vn2d_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .item       (mid_head),
    .item_pop   (mid_pop),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_taken  (res_taken)
  );

  // result queue: the output register stage
  vn2d_fifo #(
    .WIDTH (VAL_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res_value),
    .pop   (res_taken),
    .dout  (noise_value),
    .empty (empty)
  );

endmodule

// ----- dv/value_noise_2d_lattice_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_lattice_checker: scoreboard for the 2D value noise block
// Mirrors the lattice from accepted loads, predicts each query's noise value
// and compares it with the popped results in order.
// ----------------------------------------------------------------------------
module value_noise_2d_lattice_checker
  import vn2d_pkg::*;
#(
  parameter int GRID_SIZE = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic               action,
  input  logic [AXIS_W-1:0]  load_row,
  input  logic [AXIS_W-1:0]  load_col,
  input  logic [VAL_W-1:0]   load_value,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic               empty,
  input  logic               pop,
  input  logic [VAL_W-1:0]   noise_value,
  output int                 fail_count,
  output int                 noise_waiting,
  output int                 noise_checked
);

  logic [VAL_W-1:0] lattice_q [0:255][0:255];
  logic [VAL_W-1:0] noise_expected [$];

  // fractional part as Q0.16
  function automatic logic [15:0] frac_q16(input logic [COORD_W-1:0] c);
    logic [31:0] f;
    f = c & ((32'd1 << FRAC_BITS) - 32'd1);
    return 16'(f << (16 - FRAC_BITS));
  endfunction

  // smoothstep t*t*(3-2t), Q1.16, round half up
  function automatic logic [16:0] fade_weight(input logic [15:0] t);
    logic [63:0] t2, u, p;
    t2 = 64'(t) * 64'(t);
    u  = 64'd196608 - 64'(t) * 64'd2;
    p  = t2 * u;
    return 17'((p + 64'h8000_0000) >> 32);
  endfunction

  function automatic logic [15:0] mix_q16(input logic [15:0] a, input logic [15:0] b,
                                          input logic [16:0] s);
    logic [63:0] wa, wb, acc;
    wb  = 64'(s);
    wa  = 64'd65536 - wb;
    acc = 64'(a) * wa + 64'(b) * wb;
    return 16'((acc + 64'd32768) >> 16);
  endfunction

  function automatic logic [15:0] predict_noise(input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy);
    logic [31:0] ix, iy;
    logic [7:0]  x0, x1, y0, y1;
    logic [16:0] sx, sy;
    logic [15:0] near_row, far_row;
    ix = (cx >> FRAC_BITS) % 32'(GRID_SIZE - 1);
    iy = (cy >> FRAC_BITS) % 32'(GRID_SIZE - 1);
    x0 = 8'(ix & 32'(GRID_SIZE - 1));
    x1 = 8'((ix + 32'd1) & 32'(GRID_SIZE - 1));
    y0 = 8'(iy & 32'(GRID_SIZE - 1));
    y1 = 8'((iy + 32'd1) & 32'(GRID_SIZE - 1));
    sx = fade_weight(frac_q16(cx));
    sy = fade_weight(frac_q16(cy));
    near_row = mix_q16(lattice_q[x0][y0], lattice_q[x1][y0], sx);
    far_row  = mix_q16(lattice_q[x0][y1], lattice_q[x1][y1], sx);
    return mix_q16(near_row, far_row, sy);
  endfunction

  always @(posedge clk) begin : score
    int errs;
    logic [VAL_W-1:0] want;
    errs = 0;
    if (!rst) begin
      if (push && !full) begin
        if (action == ACT_LOAD) lattice_q[load_row][load_col] = load_value;
        else noise_expected.push_back(predict_noise(coord_x, coord_y));
      end
      if (pop && !empty) begin
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected noise_value, expected none, actual %h",
                   $time, noise_value);
          errs++;
        end else begin
          want = noise_expected.pop_front();
          if (noise_value !== want) begin
            $display("%0t: noise_value mismatch, expected %h, actual %h",
                     $time, want, noise_value);
            errs++;
          end
          noise_checked <= noise_checked + 1;
        end
      end
    end
    fail_count    <= fail_count + errs;
    noise_waiting <= noise_expected.size();
  end

endmodule

// ----- dv/value_noise_2d_lattice_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_lattice_top_test: testbench for the 2D value noise block
// Loads lattice entries and issues noise queries whose corners are always
// loaded first, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module value_noise_2d_lattice_top_test;
  import vn2d_pkg::*;

  localparam int GRID        = 256;
  localparam int FRAC        = 16;
  localparam int CELLS       = GRID - 1;  // integer part wraps modulo this
  localparam int ITEMS       = 850;
  localparam int CALM_AT     = 750;       // no idling from here on
  localparam int HOLD_AFTER  = 150;       // results seen before the long stall
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;      // cycles with no handshake at all
  localparam int TAIL        = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               action = ACT_LOAD;
  logic [AXIS_W-1:0]  load_row = '0;
  logic [AXIS_W-1:0]  load_col = '0;
  logic [VAL_W-1:0]   load_value = '0;
  logic [COORD_W-1:0] coord_x = '0;
  logic [COORD_W-1:0] coord_y = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [VAL_W-1:0]   noise_value;

  int  fail_count, noise_waiting, noise_checked;
  int  requests_sent = 0, loads_sent = 0, queries_sent = 0;
  int  quiet_cycles = 0, full_cycles = 0;
  bit  calm_phase = 1'b0;
  // entries loaded so far; a query is only issued once its corners are here
  bit  lattice_loaded [0:255][0:255];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  value_noise_2d_lattice_top #(.GRID_SIZE(GRID), .FRAC_BITS(FRAC)) dut (
    .clk, .rst, .push, .full, .action, .load_row, .load_col, .load_value,
    .coord_x, .coord_y, .empty, .pop, .noise_value
  );

  value_noise_2d_lattice_checker #(.GRID_SIZE(GRID), .FRAC_BITS(FRAC)) scoreboard (
    .clk, .rst, .push, .full, .action, .load_row, .load_col, .load_value,
    .coord_x, .coord_y, .empty, .pop, .noise_value,
    .fail_count, .noise_waiting, .noise_checked
  );

  // watchdog: any handshake resets it
  always @(posedge clk) begin
    if (full) full_cycles <= full_cycles + 1;
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold-off, steady at the end
  initial begin : result_side
    int  gap;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && noise_checked >= HOLD_AFTER) begin
        // long stall while requests keep coming: queues fill, full rises
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Drive one request and hold it until taken. Push is left high on return
  // so back-to-back requests never drop it within a time step.
  task automatic offer(input logic act, input logic [AXIS_W-1:0] row,
                       input logic [AXIS_W-1:0] col, input logic [VAL_W-1:0] val,
                       input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    int gap;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    action     <= act;
    load_row   <= row;
    load_col   <= col;
    load_value <= val;
    coord_x    <= cx;
    coord_y    <= cy;
    do @(posedge clk); while (full);
    requests_sent++;
  endtask

  // coordinate fields ride along as don't-care noise
  task automatic load_entry(input logic [AXIS_W-1:0] row, input logic [AXIS_W-1:0] col,
                            input logic [VAL_W-1:0] val);
    offer(ACT_LOAD, row, col, val, $urandom, $urandom);
    lattice_loaded[row][col] = 1'b1;
    loads_sent++;
  endtask

  // loads any missing corner with a random value, then queries
  task automatic query_noise(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    int x0, y0;
    x0 = (cx >> FRAC) % CELLS;
    y0 = (cy >> FRAC) % CELLS;
    for (int dx = 0; dx < 2; dx++)
      for (int dy = 0; dy < 2; dy++)
        if (!lattice_loaded[x0 + dx][y0 + dy])
          load_entry(AXIS_W'(x0 + dx), AXIS_W'(y0 + dy), VAL_W'($urandom));
    offer(ACT_QUERY, AXIS_W'($urandom), AXIS_W'($urandom), VAL_W'($urandom), cx, cy);
    queries_sent++;
  endtask

  // any integer part that wraps onto this cell
  function automatic logic [COORD_W-1:0] coord_on(input int cell_idx,
                                                  input logic [15:0] frac);
    int k;
    k = $urandom_range(0, (65535 - cell_idx) / CELLS);
    return {16'(cell_idx + k * CELLS), frac};
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int near_cell(input int base);
    int c;
    c = base + $urandom_range(0, 3);
    return (c > CELLS - 1) ? CELLS - 1 : c;
  endfunction

  initial begin : request_side
    int base_x, base_y, pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // flat full-scale cell at the origin: any weight must give full scale
    load_entry(8'd0, 8'd0, 16'hFFFF);
    load_entry(8'd1, 8'd0, 16'hFFFF);
    load_entry(8'd0, 8'd1, 16'hFFFF);
    load_entry(8'd1, 8'd1, 16'hFFFF);
    query_noise(32'h0000_0000, 32'h0000_0000);
    query_noise(32'h0000_FFFF, 32'h0000_FFFF);
    // hard step across the last cell, neighbor index reaches 255
    load_entry(8'd254, 8'd254, 16'h0000);
    load_entry(8'd255, 8'd254, 16'hFFFF);
    load_entry(8'd254, 8'd255, 16'h0000);
    load_entry(8'd255, 8'd255, 16'hFFFF);
    query_noise(32'h00FE_0000, 32'h00FE_8000);
    query_noise(32'h00FE_8000, 32'h00FE_0001);
    query_noise(32'hFFFE_FFFF, 32'hFFFE_FFFF);  // top of range, still cell 254
    // integer parts 65535 and 255 both wrap back to cell 0
    query_noise(32'hFFFF_FFFF, 32'h00FF_0000);
    // uneven corners at the origin
    load_entry(8'd1, 8'd0, 16'h0000);
    load_entry(8'd0, 8'd1, 16'h8000);
    query_noise(32'h0000_8000, 32'h0000_4000);
    // ignored fields all ones: coords on a load, load fields on a query
    offer(ACT_LOAD, 8'd1, 8'd1, 16'h1234, '1, '1);
    loads_sent++;
    offer(ACT_QUERY, '1, '1, '1, 32'h0000_C000, 32'h0000_2000);
    queries_sent++;

    // random part: mostly queries clustered in a small window so corners get
    // reused, with stray loads and scattered queries mixed in
    base_x = 0;
    base_y = 0;
    while (requests_sent < ITEMS) begin
      if (requests_sent >= CALM_AT && !calm_phase) calm_phase <= 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0:       begin base_x = 0;         base_y = CELLS - 1; end
          1:       begin base_x = CELLS - 1; base_y = 0;         end
          default: begin
            base_x = $urandom_range(0, CELLS - 1);
            base_y = $urandom_range(0, CELLS - 1);
          end
        endcase
      end
      pick = $urandom_range(0, 19);
      if (pick < 14)
        query_noise(coord_on(near_cell(base_x), pick_frac()),
                    coord_on(near_cell(base_y), pick_frac()));
      else if (pick < 17)
        load_entry(AXIS_W'($urandom_range(0, 255)), AXIS_W'($urandom_range(0, 255)),
                   VAL_W'($urandom));
      else if (pick < 18)
        load_entry(AXIS_W'(near_cell(base_x)), AXIS_W'(near_cell(base_y)),
                   VAL_W'($urandom));  // rewrite in use
      else
        query_noise(coord_on($urandom_range(0, CELLS - 1), pick_frac()),
                    coord_on($urandom_range(0, CELLS - 1), pick_frac()));
    end

    push <= 1'b0;
    @(posedge clk);
    while (noise_waiting != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d lattice loads and %0d noise queries; %0d results compared.",
             loads_sent, queries_sent, noise_checked);
    $display("Input held off by full for %0d cycles, mostly during a %0d-cycle stall.",
             full_cycles, HOLD_CYCLES);
    if (fail_count == 0 && noise_waiting == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- value_noise_2d_lattice_top.f -----
design/vn2d_pkg.sv
design/vn2d_fifo.sv
design/vn2d_front.sv
design/vn2d_back.sv
design/value_noise_2d_lattice_top.sv
dv/value_noise_2d_lattice_checker.sv
dv/value_noise_2d_lattice_top_test.sv
